[hw/rtl/dq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// shared constants, codes and item types of the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = 5;
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } dq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } dq_state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_in;
  } dq_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic [4:0] occupancy;
  } dq_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dq_cmd_t;

endpackage : dq_pkg
`default_nettype wire

[hw/rtl/dq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// sequencer: take an item, execute it, hold the result until taken
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output dq_pkg::dq_cmd_t     cmd_o
);
  import dq_pkg::*;

  dq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule : dq_ctrl
`default_nettype wire

[hw/rtl/dq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// circular element store with head pointer, count and result registers
// ----------------------------------------------------------------------------
module dq_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dq_pkg::dq_cmd_t cmd_i,
  input  wire dq_pkg::dq_in_t  in_item_i,
  output dq_pkg::dq_out_t      out_item_o
);
  import dq_pkg::*;

  logic [7:0]       mem_q [DEPTH];
  logic [7:0]       rd_q;

  logic [2:0]       op_q;
  logic [7:0]       data_q;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             use_rd_q, use_rd_d;
  dq_status_e       status_q, status_d;

  logic             full, empty, wr_en;
  logic [IDX_W-1:0] head_inc, head_dec, tail_idx, rear_idx, wr_addr, rd_addr;
  logic [SUM_W-1:0] tail_sum, rear_sum;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);

  // tail is one past the rear, rear is only used when not empty
  assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign rear_sum = tail_sum - SUM_W'(1);
  assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                : IDX_W'(tail_sum);
  assign rear_idx = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                : IDX_W'(rear_sum);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    use_rd_d = 1'b0;
    status_d = ST_OK;
    wr_en    = 1'b0;
    wr_addr  = tail_idx;
    rd_addr  = head_q;
    unique case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head_dec;
          head_d  = head_dec;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          use_rd_d = 1'b1;
          head_d   = head_inc;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_POP_REAR: begin
        rd_addr = rear_idx;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          use_rd_d = 1'b1;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_PEEK_FRONT: begin
        if (empty) status_d = ST_EMPTY;
        else use_rd_d = 1'b1;
      end
      OP_PEEK_REAR: begin
        rd_addr = rear_idx;
        if (empty) status_d = ST_EMPTY;
        else use_rd_d = 1'b1;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // pointer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // item capture and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_item_i.opcode;
      data_q <= in_item_i.data_in;
    end
    if (cmd_i.exec) begin
      use_rd_q <= use_rd_d;
      status_q <= status_d;
    end
  end

  // element store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem_q[wr_addr] <= data_q;
    if (cmd_i.exec) rd_q <= mem_q[rd_addr];
  end

  assign out_item_o.data_out  = use_rd_q ? rd_q : 8'd0;
  assign out_item_o.status    = status_q;
  assign out_item_o.occupancy = count_q;

endmodule : dq_datapath
`default_nettype wire

[hw/rtl/double_ended_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core
// double-ended queue of bytes in a circular store of DEPTH entries
// ----------------------------------------------------------------------------
// an accepted item is captured in idle, executed in exec and its result held in resp
// items run one at a time (accept, execute with store access, present), as
//   set by the one-item sequencer and the registered store read
// a stalled result holds the block; the next item is taken after it leaves
// reset: asynchronous active low, clears head pointer, count and sequencer;
//   store contents are undefined until written, no clearing pass
module double_ended_queue_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire dq_pkg::dq_in_t  in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output dq_pkg::dq_out_t      out_item_o
);
  import dq_pkg::*;

  // load captures the item, exec updates pointers, writes at most one entry and reads one
  dq_cmd_t cmd;

  // sequencer: idle takes an item, exec runs it, resp holds the result
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // store, head pointer, count; result fields stay registered while stalled
  dq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule : double_ended_queue_core
`default_nettype wire

[tb/double_ended_queue_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// self-checking bench for the byte deque: a clocked driver feeds items from a
// backlog, a clocked monitor checks every result against a mirror of the
// deque, with random idling on both sides, long receiver hold-offs and
// sender pauses that let the block drain
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CALM_TAIL = 120;   // backlog size below which nobody idles
  localparam int unsigned HOLD_CYCLES = 80;  // length of a long receiver hold-off
  localparam int unsigned HOLD_EVERY = 300;  // items taken between hold-offs
  localparam int unsigned HOLD_COUNT = 2;

  // one pending item; settle makes the sender wait until all results are back
  typedef struct {
    dq_in_t item;
    bit     settle;
  } queued_op_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  dq_in_t  in_item_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  dq_out_t out_item_o;

  // items still to send, and results owed by the block in order
  queued_op_t op_backlog[$];
  dq_out_t    owed_results[$];

  // mirror of the deque contents
  logic [7:0]  mirror_store[DEPTH];
  int unsigned mirror_head = 0;
  int unsigned mirror_count = 0;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          settle_next = 1'b0;

  // sender idling state
  int unsigned tx_gap_left = 0;
  int unsigned tx_phase_left = 0;
  bit          tx_idling = 1'b0;

  // receiver idling state
  int unsigned rx_gap_left = 0;
  int unsigned rx_phase_left = 0;
  bit          rx_idling = 1'b0;

  // long hold-off of the receiver, counted in its own process
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  logic        rx_hold;

  // no idling once the run is close to its end
  wire calm = (op_backlog.size() < CALM_TAIL);

  assign rx_hold = (hold_left != 0);

  double_ended_queue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // applies one operation to the mirror and gives the result the block owes
  function automatic dq_out_t deque_apply(dq_in_t it);
    dq_out_t res;
    int unsigned rear;
    res = '0;
    res.status = ST_OK;
    rear = (mirror_head + mirror_count + DEPTH - 1) % DEPTH;
    case (it.opcode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (mirror_count >= DEPTH) begin
          // refused, nothing moves
          res.status = ST_FULL;
        end else if (it.opcode == OP_PUSH_FRONT) begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_store[mirror_head] = it.data_in;
          mirror_count++;
        end else begin
          mirror_store[(mirror_head + mirror_count) % DEPTH] = it.data_in;
          mirror_count++;
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else if (it.opcode == OP_POP_FRONT || it.opcode == OP_PEEK_FRONT) begin
          res.data_out = mirror_store[mirror_head];
          if (it.opcode == OP_POP_FRONT) begin
            mirror_head = (mirror_head + 1) % DEPTH;
            mirror_count--;
          end
        end else begin
          res.data_out = mirror_store[rear];
          if (it.opcode == OP_POP_REAR) mirror_count--;
        end
      end
      default: begin
        // unused opcode, only reports the count
      end
    endcase
    res.occupancy = mirror_count[4:0];
    return res;
  endfunction

  task automatic add_op(logic [2:0] op, logic [7:0] byte_val);
    queued_op_t q;
    q.item.opcode = op;
    q.item.data_in = byte_val;
    q.settle = settle_next;
    settle_next = 1'b0;
    op_backlog.push_back(q);
    items_queued++;
  endtask

  task automatic note_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // driver: offers items from the backlog, holds a stalled item steady
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit         offer;
    queued_op_t next_op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        // item taken at this edge, predict its result now
        owed_results.push_back(deque_apply(in_item_i));
        items_taken <= items_taken + 1;
        offer = 1'b0;
      end
      // alternate stretches with and without idling
      if (tx_phase_left == 0) begin
        tx_phase_left = $urandom_range(20, 80);
        tx_idling = 1'($urandom_range(0, 1));
      end else begin
        tx_phase_left--;
      end
      if (!offer) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (op_backlog.size() > 0 &&
                     !(op_backlog[0].settle && owed_results.size() != 0)) begin
          if (tx_idling && !calm && $urandom_range(0, 3) == 0) begin
            // start an idle burst, counted down in tx_gap_left
            tx_gap_left = $urandom_range(0, 3);
          end else begin
            next_op = op_backlog.pop_front();
            in_item_i <= next_op.item;
            offer = 1'b1;
          end
        end
      end
      in_valid_i <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // long hold-offs: receiver stops taking results while the sender keeps going
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < HOLD_COUNT && items_taken >= (holds_done + 1) * HOLD_EVERY) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each taken result against the oldest owed one
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dq_out_t want;
    bit      stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          note_mismatch("result with no item outstanding");
        end else begin
          want = owed_results.pop_front();
          if (out_item_o.data_out !== want.data_out)
            note_mismatch($sformatf("data_out got %h want %h",
                                    out_item_o.data_out, want.data_out));
          if (out_item_o.status !== want.status)
            note_mismatch($sformatf("status got %0d want %0d",
                                    out_item_o.status, want.status));
          if (out_item_o.occupancy !== want.occupancy)
            note_mismatch($sformatf("occupancy got %0d want %0d",
                                    out_item_o.occupancy, want.occupancy));
        end
      end
      if (rx_phase_left == 0) begin
        rx_phase_left = $urandom_range(20, 80);
        rx_idling = 1'($urandom_range(0, 1));
      end else begin
        rx_phase_left--;
      end
      stall = 1'b0;
      if (rx_gap_left > 0) begin
        rx_gap_left--;
        stall = 1'b1;
      end else if (rx_idling && !calm && $urandom_range(0, 3) == 0) begin
        rx_gap_left = $urandom_range(0, 3);
        stall = 1'b1;
      end
      out_stall_i <= stall || rx_hold;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned kind;
    int unsigned seg_len;
    logic [2:0]  op;

    // directed: empty deque, unused opcodes, both ends, byte extremes
    add_op(OP_POP_FRONT, 8'h00);
    add_op(OP_POP_REAR, 8'hFF);
    add_op(OP_PEEK_FRONT, 8'h00);
    add_op(OP_PEEK_REAR, 8'hFF);
    add_op(3'd6, 8'hFF);
    add_op(3'd7, 8'h00);
    add_op(OP_PUSH_FRONT, 8'h00);   // head wraps below zero
    add_op(OP_PUSH_REAR, 8'hFF);
    add_op(OP_PUSH_FRONT, 8'h5A);
    add_op(OP_PEEK_FRONT, 8'h00);
    add_op(OP_PEEK_REAR, 8'h00);
    add_op(OP_POP_REAR, 8'h00);
    add_op(OP_POP_FRONT, 8'h00);
    add_op(OP_POP_FRONT, 8'h00);
    add_op(OP_POP_REAR, 8'h00);     // empty again
    add_op(OP_PUSH_REAR, 8'h81);
    add_op(OP_PUSH_FRONT, 8'h7E);
    add_op(3'd7, 8'hFF);            // ignored with items held
    add_op(OP_POP_FRONT, 8'h00);
    add_op(OP_POP_FRONT, 8'h00);
    settle_next = 1'b1;

    // random segments: filling runs push toward full, draining runs pop toward empty
    while (items_queued < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      seg_len = (kind < 2) ? $urandom_range(18, 34) : $urandom_range(4, 24);
      repeat (seg_len) begin
        case (kind)
          0, 1: op = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 1))
                                                : 3'($urandom_range(2, 5));
          2, 3: op = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(2, 5))
                                                : 3'($urandom_range(0, 1));
          4:    op = 3'($urandom_range(0, 7));
          default: op = 3'($urandom_range(0, 5));
        endcase
        add_op(op, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 11) == 0) settle_next = 1'b1;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_taken == items_queued);
    wait (owed_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue_core.sv
tb/double_ended_queue_core_tb.sv
